### src/idc_pkg.sv
// Shared types, character codes and widths for the infix decimal calculator.
package idc_pkg;

    // Internal arithmetic width and the fixed width of the result fields
    localparam int DATA_WIDTH = 32;
    localparam int OUT_W      = 32;
    localparam int CHAR_W     = 8;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] BLANK_LIMIT  = 8'd33;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_STAR    = 8'h2A;
    localparam logic [CHAR_W-1:0] CHAR_SLASH   = 8'h2F;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // Controller to datapath
    typedef struct packed {
        logic acc_left;
        logic acc_right;
        logic set_op;
        logic clear_line;
        logic latch_calc;
        logic calc_alu;
        logic div_start;
        logic take_quot;
        logic load_out;
    } idc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic blank;
        logic digit;
        logic oper;
        logic newline;
        logic op_div;
        logic b_zero;
        logic div_done;
    } idc_stat_t;

endpackage

### src/idc_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module idc_divider (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [idc_pkg::DATA_WIDTH-1:0] dividend,
    input  logic [idc_pkg::DATA_WIDTH-1:0] divisor,
    output logic                           done,
    output logic [idc_pkg::DATA_WIDTH-1:0] quotient
);
    import idc_pkg::*;

    localparam int W     = DATA_WIDTH;
    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     rem_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     dvs_reg;
    logic             neg_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [W:0]       shifted;
    logic [W:0]       diff;
    logic             last_step;

    // Restoring step on the partial remainder
    assign shifted   = {rem_reg, quo_reg[W-1]};
    assign diff      = shifted - {1'b0, dvs_reg};
    assign last_step = (cnt_reg == CNT_W'(W - 1));

    // Control: step counter, busy and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                    busy_reg <= 1'b0;
            end
        end
    end

    // Datapath: magnitudes loaded at start, then one bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend[W-1] ? (W'(0) - dividend) : dividend;
            dvs_reg <= divisor[W-1] ? (W'(0) - divisor) : divisor;
            neg_reg <= dividend[W-1] ^ divisor[W-1];
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_reg <= diff[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (W'(0) - quo_reg) : quo_reg;

endmodule

### src/idc_datapath.sv
// Datapath: character classing, operand accumulators, ALU, divider and result register.
module idc_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [idc_pkg::CHAR_W-1:0] in_char,
    input  idc_pkg::idc_cmd_t          cmd,
    output idc_pkg::idc_stat_t         stat,
    output logic [idc_pkg::OUT_W-1:0]  out_left,
    output logic [idc_pkg::OUT_W-1:0]  out_right,
    output logic [1:0]                 out_op,
    output logic [idc_pkg::OUT_W-1:0]  out_result,
    output logic                       out_dz
);
    import idc_pkg::*;

    localparam int W = DATA_WIDTH;

    logic [W-1:0]     left_reg;
    logic [W-1:0]     right_reg;
    op_t              op_reg;
    logic [W-1:0]     a_reg;
    logic [W-1:0]     b_reg;
    op_t              calc_op_reg;
    logic [W-1:0]     res_reg;
    logic             dz_reg;
    logic [OUT_W-1:0] out_left_reg;
    logic [OUT_W-1:0] out_right_reg;
    op_t              out_op_reg;
    logic [OUT_W-1:0] out_result_reg;
    logic             out_dz_reg;

    op_t              char_op;
    logic             char_is_op;
    logic [W-1:0]     digit_val;
    logic [W-1:0]     product;
    logic             div_done;
    logic [W-1:0]     quotient;

    // Character classing
    always_comb
    begin
        char_is_op = 1'b1;
        case (in_char)
            CHAR_PLUS:  char_op = OP_ADD;
            CHAR_MINUS: char_op = OP_SUB;
            CHAR_STAR:  char_op = OP_MUL;
            CHAR_SLASH: char_op = OP_DIV;
            default:
            begin
                char_op    = OP_ADD;
                char_is_op = 1'b0;
            end
        endcase
    end

    assign digit_val = W'(in_char - CHAR_ZERO);

    assign stat.blank    = (in_char < BLANK_LIMIT);
    assign stat.digit    = (in_char >= CHAR_ZERO) && (in_char <= CHAR_NINE);
    assign stat.oper     = char_is_op;
    assign stat.newline  = (in_char == CHAR_NEWLINE);
    assign stat.op_div   = (calc_op_reg == OP_DIV);
    assign stat.b_zero   = (b_reg == '0);
    assign stat.div_done = div_done;

    // Line accumulators: value * 10 + digit, wrapping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= '0;
            right_reg <= '0;
            op_reg    <= OP_ADD;
        end
        else
        begin
            if (cmd.clear_line)
            begin
                left_reg  <= '0;
                right_reg <= '0;
                op_reg    <= OP_ADD;
            end
            else
            begin
                if (cmd.acc_left)
                    left_reg <= (left_reg << 3) + (left_reg << 1) + digit_val;
                if (cmd.acc_right)
                    right_reg <= (right_reg << 3) + (right_reg << 1) + digit_val;
                if (cmd.set_op)
                    op_reg <= char_op;
            end
        end
    end

    // Operands frozen for the calculation at the newline
    always_ff @(posedge clk)
    begin
        if (cmd.latch_calc)
        begin
            a_reg       <= left_reg;
            b_reg       <= right_reg;
            calc_op_reg <= op_reg;
        end
    end

    assign product = a_reg * b_reg;

    // Result register: ALU ops, divide by zero, or divider quotient
    always_ff @(posedge clk)
    begin
        if (cmd.calc_alu)
        begin
            dz_reg <= 1'b0;
            case (calc_op_reg)
                OP_ADD: res_reg <= a_reg + b_reg;
                OP_SUB: res_reg <= a_reg - b_reg;
                OP_MUL: res_reg <= product;
                default:
                begin
                    res_reg <= '0;
                    dz_reg  <= 1'b1;
                end
            endcase
        end
        else if (cmd.take_quot)
        begin
            res_reg <= quotient;
            dz_reg  <= 1'b0;
        end
    end

    // Output register, held until the beat is taken
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_left_reg   <= OUT_W'(a_reg);
            out_right_reg  <= OUT_W'(b_reg);
            out_op_reg     <= calc_op_reg;
            out_result_reg <= OUT_W'(res_reg);
            out_dz_reg     <= dz_reg;
        end
    end

    idc_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (a_reg),
        .divisor  (b_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign out_left   = out_left_reg;
    assign out_right  = out_right_reg;
    assign out_op     = out_op_reg;
    assign out_result = out_result_reg;
    assign out_dz     = out_dz_reg;

endmodule

### src/idc_ctrl.sv
// Controller: line parser state machine and calculation sequencer.
module idc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  idc_pkg::idc_stat_t stat,
    output idc_pkg::idc_cmd_t  cmd
);
    import idc_pkg::*;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_LEFT,
        PH_PRE_OP,
        PH_POST_OP,
        PH_RIGHT,
        PH_TRAIL,
        PH_DISCARD
    } phase_t;

    typedef enum logic [1:0] {
        SQ_PARSE,
        SQ_CALC,
        SQ_DIV,
        SQ_DONE
    } seq_t;

    phase_t phase_reg, phase_next;
    seq_t   seq_reg, seq_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   emit;

    assign accept = s_axis_tvalid && (seq_reg == SQ_PARSE);
    assign emit   = (phase_reg == PH_POST_OP) || (phase_reg == PH_RIGHT)
                 || (phase_reg == PH_TRAIL);

    // Next state and commands
    always_comb
    begin
        phase_next     = phase_reg;
        seq_next       = seq_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        // Parse one accepted character
        if (accept)
        begin
            if (stat.newline)
            begin
                cmd.clear_line = 1'b1;
                phase_next     = PH_LEAD;
                if (emit)
                begin
                    cmd.latch_calc = 1'b1;
                    seq_next       = SQ_CALC;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_LEAD, PH_LEFT, PH_PRE_OP:
                    begin
                        if (stat.blank)
                        begin
                            if (phase_reg == PH_LEFT)
                                phase_next = PH_PRE_OP;
                        end
                        else if (stat.digit && phase_reg != PH_PRE_OP)
                        begin
                            cmd.acc_left = 1'b1;
                            phase_next   = PH_LEFT;
                        end
                        else if (stat.oper)
                        begin
                            cmd.set_op = 1'b1;
                            phase_next = PH_POST_OP;
                        end
                        else
                            phase_next = PH_DISCARD;
                    end
                    PH_POST_OP, PH_RIGHT:
                    begin
                        if (stat.blank)
                        begin
                            if (phase_reg == PH_RIGHT)
                                phase_next = PH_TRAIL;
                        end
                        else if (stat.digit)
                        begin
                            cmd.acc_right = 1'b1;
                            phase_next    = PH_RIGHT;
                        end
                        else
                            phase_next = PH_DISCARD;
                    end
                    PH_TRAIL:
                    begin
                        if (!stat.blank)
                            phase_next = PH_DISCARD;
                    end
                    default:
                        phase_next = PH_DISCARD;
                endcase
            end
        end

        // Calculation sequencer
        case (seq_reg)
            SQ_PARSE: ;
            SQ_CALC:
            begin
                if (stat.op_div && !stat.b_zero)
                begin
                    cmd.div_start = 1'b1;
                    seq_next      = SQ_DIV;
                end
                else
                begin
                    cmd.calc_alu = 1'b1;
                    seq_next     = SQ_DONE;
                end
            end
            SQ_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.take_quot = 1'b1;
                    seq_next      = SQ_DONE;
                end
            end
            SQ_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    cmd.load_out = 1'b1;
                    seq_next     = SQ_PARSE;
                end
            end
            default:
                seq_next = SQ_PARSE;
        endcase

        // Output beat valid
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEAD;
            seq_reg       <= SQ_PARSE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            seq_reg       <= seq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_axis_tready = (seq_reg == SQ_PARSE);
    assign m_axis_tvalid = out_valid_reg;

`ifndef SYNTH
    // A waiting result beat is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || m_axis_tready))
        else $error("result register loaded over a pending beat");

    // The divider only starts on a divide with a nonzero divisor
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> (stat.op_div && !stat.b_zero))
        else $error("divider started without a valid divide");

    // A new result beat only follows the done step
    a_valid_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(seq_reg == SQ_DONE))
        else $error("result valid raised outside the done step");

    // An emitting newline moves the sequencer off the parse step
    a_newline_calc: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && stat.newline && emit) |=> (seq_reg == SQ_CALC))
        else $error("line end did not start a calculation");
`endif

endmodule

### src/infix_decimal_calculator.sv
// Top level of the infix decimal calculator: parser, ALU and iterative divider.
// Throughput: one character per cycle while a line is parsed.
// A newline that ends a line with an operator holds s_axis_tready low in the calc and done
// steps on add, subtract, multiply and divide by zero, and also while the divider runs (one
// quotient bit per cycle); the result beat is valid when tready returns, and a still pending
// earlier beat adds its wait. Lines without an operator or with a bad character give no beat.
// Reset (rst_n low, asynchronous) returns to line start with cleared operands, no beat pending.
module infix_decimal_calculator (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] character
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // [31:0] left_operand, [63:32] right_operand,
                                         // [95:64] result
    output logic [2:0]   m_axis_tuser    // [1:0] operation, [2] divide_by_zero
);
    import idc_pkg::*;

    idc_cmd_t         cmd;
    idc_stat_t        stat;
    logic [OUT_W-1:0] out_left;
    logic [OUT_W-1:0] out_right;
    logic [1:0]       out_op;
    logic [OUT_W-1:0] out_result;
    logic             out_dz;

    idc_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    idc_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_char    (s_axis_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .out_left   (out_left),
        .out_right  (out_right),
        .out_op     (out_op),
        .out_result (out_result),
        .out_dz     (out_dz)
    );

    // Pack the result beat
    assign m_axis_tdata = {out_result, out_right, out_left};
    assign m_axis_tuser = {out_dz, out_op};

endmodule

### bench/tb_infix_decimal_calculator.sv
// Self-checking testbench for the infix decimal calculator: directed and random lines.
module tb_infix_decimal_calculator;
    timeunit 1ns;
    timeprecision 1ps;

    import idc_pkg::*;

    // Parser position within a line
    typedef enum logic [2:0] {
        LINE_START,
        IN_LEFT,
        AFTER_LEFT,
        AFTER_OP,
        IN_RIGHT,
        AFTER_RIGHT,
        SKIP_LINE
    } parse_phase_t;

    // One expected answer beat
    typedef struct {
        logic [31:0] left_op;
        logic [31:0] right_op;
        op_t         op;
        logic [31:0] value;
        logic        div_zero;
    } calc_answer_t;

    localparam int TAIL_CYCLES = DATA_WIDTH + 16;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;    // [7:0] character
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;    // [31:0] left_operand, [63:32] right_operand, [95:64] result
    logic [2:0]   m_axis_tuser;    // [1:0] operation, [2] divide_by_zero

    // Shadow parser state
    parse_phase_t      line_phase;
    logic [31:0]       left_acc;
    logic [31:0]       right_acc;
    op_t               line_op;
    logic              line_has_op;

    calc_answer_t      pending_answers[$];

    int  errors;
    int  chars_sent;
    int  lines_sent;
    int  answers_checked;
    int  div_zero_seen;
    bit  idle_on;

    infix_decimal_calculator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 50 MHz clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Hard stop if the run hangs
    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int draw_gap();
        return idle_on ? $urandom_range(0, 3) : 0;
    endfunction

    // Arithmetic on the parsed line, 32-bit wrapping, divide truncates toward zero
    function automatic calc_answer_t evaluate_line(logic [31:0] a, logic [31:0] b, op_t op);
        calc_answer_t ans;
        logic [31:0]  mag_a;
        logic [31:0]  mag_b;
        logic [31:0]  quot;
        ans.left_op  = a;
        ans.right_op = b;
        ans.op       = op;
        ans.div_zero = 1'b0;
        case (op)
            OP_ADD: ans.value = a + b;
            OP_SUB: ans.value = a - b;
            OP_MUL: ans.value = a * b;
            default:
            begin
                if (b == 32'd0)
                begin
                    ans.value    = 32'd0;
                    ans.div_zero = 1'b1;
                end
                else
                begin
                    mag_a = a[31] ? -a : a;
                    mag_b = b[31] ? -b : b;
                    quot  = mag_a / mag_b;
                    if (a[31] ^ b[31])
                        quot = -quot;
                    ans.value = quot;
                end
            end
        endcase
        return ans;
    endfunction

    function automatic void clear_shadow_line();
        line_phase  = LINE_START;
        left_acc    = 32'd0;
        right_acc   = 32'd0;
        line_op     = OP_ADD;
        line_has_op = 1'b0;
    endfunction

    // Advance the shadow parser by one accepted character
    task automatic parse_char(input logic [7:0] c);
        logic blank;
        logic digit;
        logic is_op;
        op_t  op_val;
        blank  = c < BLANK_LIMIT;
        digit  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        is_op  = 1'b1;
        op_val = OP_ADD;
        case (c)
            CHAR_PLUS:  op_val = OP_ADD;
            CHAR_MINUS: op_val = OP_SUB;
            CHAR_STAR:  op_val = OP_MUL;
            CHAR_SLASH: op_val = OP_DIV;
            default:    is_op = 1'b0;
        endcase

        if (c == CHAR_NEWLINE)
        begin
            lines_sent++;
            if (line_phase != SKIP_LINE && line_has_op)
                pending_answers.push_back(evaluate_line(left_acc, right_acc, line_op));
            clear_shadow_line();
        end
        else
        begin
            case (line_phase)
                LINE_START, IN_LEFT, AFTER_LEFT:
                begin
                    if (blank)
                    begin
                        if (line_phase == IN_LEFT)
                            line_phase = AFTER_LEFT;
                    end
                    else if (digit && line_phase != AFTER_LEFT)
                    begin
                        left_acc   = left_acc * 32'd10 + {24'd0, c - CHAR_ZERO};
                        line_phase = IN_LEFT;
                    end
                    else if (is_op)
                    begin
                        line_op     = op_val;
                        line_has_op = 1'b1;
                        line_phase  = AFTER_OP;
                    end
                    else
                        line_phase = SKIP_LINE;
                end
                AFTER_OP, IN_RIGHT:
                begin
                    if (blank)
                    begin
                        if (line_phase == IN_RIGHT)
                            line_phase = AFTER_RIGHT;
                    end
                    else if (digit)
                    begin
                        right_acc  = right_acc * 32'd10 + {24'd0, c - CHAR_ZERO};
                        line_phase = IN_RIGHT;
                    end
                    else
                        line_phase = SKIP_LINE;
                end
                AFTER_RIGHT:
                begin
                    if (!blank)
                        line_phase = SKIP_LINE;
                end
                default: line_phase = SKIP_LINE;
            endcase
        end
    endtask

    // Send one character beat; tvalid stays high afterwards in case another follows
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        do
            @(posedge clk);
        while (!s_axis_tready);
        chars_sent++;
        parse_char(c);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic send_line(input string s);
        send_text(s);
        send_char(CHAR_NEWLINE);
    endtask

    // Drop tvalid before any wait that is not a handshake
    task automatic release_input();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_answers_drained();
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    // Random blank other than newline
    task automatic send_blanks(input int n);
        int b;
        repeat (n)
        begin
            b = $urandom_range(0, 32);
            if (b == CHAR_NEWLINE)
                b = 32;
            send_char(8'(b));
        end
    endtask

    // Decimal operand, mostly short, sometimes wrapping or an edge value
    task automatic send_operand();
        int kind;
        int n;
        kind = $urandom_range(0, 19);
        case (kind)
            0:  ;
            1:  send_text("0");
            2:  send_text("4294967295");
            3:  send_text("2147483648");
            4:  send_text("2147483647");
            5:  send_text("000");
            6, 7:
            begin
                n = $urandom_range(5, 12);
                repeat (n) send_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
            default:
            begin
                n = $urandom_range(1, 4);
                repeat (n) send_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
        endcase
    endtask

    task automatic send_operator();
        case ($urandom_range(0, 3))
            0: send_char(CHAR_PLUS);
            1: send_char(CHAR_MINUS);
            2: send_char(CHAR_STAR);
            default: send_char(CHAR_SLASH);
        endcase
    endtask

    // Well-formed line; bad_slot selects where a stray non-blank byte goes (-1: none)
    task automatic send_expression(input int bad_slot);
        for (int slot = 0; slot < 6; slot++)
        begin
            if (slot == bad_slot)
                send_char(8'($urandom_range(33, 255)));
            case (slot)
                0: send_blanks($urandom_range(0, 2));
                1: send_operand();
                2: send_blanks($urandom_range(0, 2));
                3: send_operator();
                4: send_blanks($urandom_range(0, 2));
                default:
                begin
                    send_operand();
                    send_blanks($urandom_range(0, 2));
                end
            endcase
        end
        send_char(CHAR_NEWLINE);
    endtask

    // Compare one answer beat with the oldest expectation
    task automatic check_answer();
        calc_answer_t exp_ans;
        logic [31:0]  act_left;
        logic [31:0]  act_right;
        logic [31:0]  act_value;
        logic [1:0]   act_op;
        logic         act_dz;
        act_left  = m_axis_tdata[31:0];
        act_right = m_axis_tdata[63:32];
        act_value = m_axis_tdata[95:64];
        act_op    = m_axis_tuser[1:0];
        act_dz    = m_axis_tuser[2];
        if (act_dz === 1'b1)
            div_zero_seen++;
        if (pending_answers.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("[%0t] unexpected answer beat: left=%0d right=%0d op=%0d result=%0d dz=%b",
                         $realtime, $signed(act_left), $signed(act_right), act_op,
                         $signed(act_value), act_dz);
            return;
        end
        exp_ans = pending_answers.pop_front();
        answers_checked++;
        if (act_left !== exp_ans.left_op || act_right !== exp_ans.right_op ||
            act_op !== exp_ans.op || act_value !== exp_ans.value ||
            act_dz !== exp_ans.div_zero)
        begin
            errors++;
            if (errors <= 10)
            begin
                $display("[%0t] answer mismatch #%0d", $realtime, errors);
                $display("  expected: left=%0d right=%0d op=%s result=%0d dz=%b",
                         $signed(exp_ans.left_op), $signed(exp_ans.right_op),
                         exp_ans.op.name(), $signed(exp_ans.value), exp_ans.div_zero);
                $display("  actual:   left=%0d right=%0d op=%0d result=%0d dz=%b",
                         $signed(act_left), $signed(act_right), act_op,
                         $signed(act_value), act_dz);
            end
        end
    endtask

    // Answer side: random back-pressure while a beat is offered
    initial
    begin : answer_sink
        int gap;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        m_axis_tready <= 1'b1;
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
                do
                    @(posedge clk);
                while (!m_axis_tvalid);
                repeat (gap) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            check_answer();
        end
    end

    // Every operator, blanks of several kinds, signed truncation
    task automatic test_basic_operations();
        send_line("7+5");
        send_line(" 9 - 12 ");
        send_line("\t123*456 ");
        send_line("100/7");
        send_line("4294967289/2");
    endtask

    // Missing operands, divide by zero, wrap and most negative over minus one
    task automatic test_operand_edge_cases();
        send_line("-7");
        send_line("8*");
        send_line("5/0");
        send_line("5/");
        send_line("2147483648/4294967295");
        send_line("4294967296+1");
        send_line("2147483647+1");
    endtask

    // Lines that must give no answer, plus extreme byte values and good lines between them
    task automatic test_malformed_lines();
        send_line("12 34+1");
        send_line("12");
        send_line("1+2 3");
        send_line("1++2");
        send_line("1+2x");
        send_char(8'hFF);
        send_line("+1");
        send_char(8'h00);
        send_line("3+3");
        send_char(8'h80);
        send_line("");
        send_line("6*7");
    endtask

    // Sender holds off until the answer queue is empty, then resumes back to back
    task automatic test_drain_pause();
        send_line("99/3");
        send_line("1-2");
        release_input();
        wait_answers_drained();
        idle_on = 1'b0;
        send_line("250/5");
        send_line("3*3");
        idle_on = 1'b1;
    endtask

    // Mostly well-formed random lines with some corrupted and noise lines
    task automatic test_random_lines(input int char_budget);
        int start_chars;
        int pick;
        int n;
        start_chars = chars_sent;
        while (chars_sent - start_chars < char_budget)
        begin
            if ($urandom_range(0, 9) == 0)
                idle_on = !idle_on;
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_expression(-1);
            else if (pick < 85)
                send_expression($urandom_range(0, 5));
            else if (pick < 93)
            begin
                n = $urandom_range(1, 12);
                repeat (n) send_char(8'($urandom_range(0, 255)));
                send_char(CHAR_NEWLINE);
            end
            else
            begin
                send_blanks($urandom_range(0, 2));
                send_operand();
                send_blanks($urandom_range(0, 2));
                send_char(CHAR_NEWLINE);
            end
        end
        idle_on = 1'b1;
    endtask

    // Main sequence
    initial
    begin
        rst_n           = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = 8'd0;
        errors          = 0;
        chars_sent      = 0;
        lines_sent      = 0;
        answers_checked = 0;
        div_zero_seen   = 0;
        idle_on         = 1'b1;
        clear_shadow_line();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_operations();
        test_operand_edge_cases();
        test_malformed_lines();
        test_drain_pause();
        test_random_lines(1340);

        release_input();
        wait_answers_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d characters in %0d lines; checked %0d answers (%0d divide by zero).",
                 chars_sent, lines_sent, answers_checked, div_zero_seen);
        $display("Covered all operators, operand wrap, malformed lines and random stalls.");
        if (errors == 0 && pending_answers.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
